/* src/hill_block_cipher_assert.svh */
// Assertion macros shared by the cipher's RTL files.
`ifndef HILL_BLOCK_CIPHER_ASSERT_SVH
`define HILL_BLOCK_CIPHER_ASSERT_SVH

// Checks that the condition holds in the same cycle as the trigger.
`define HBC_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Checks that the condition holds in the cycle after the trigger.
`define HBC_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

/* src/hbc_pkg.sv */
// Shared types and constants of the Hill block cipher.
package hbc_pkg;

	localparam int MAX_SIZE = 4;
	localparam int IDX_W = 2;

	localparam logic [10:0] EN_OFFSET = 11'd65;
	localparam logic [10:0] EN_LAST = 11'd90;
	localparam logic [10:0] RU_OFFSET = 11'd1040;
	localparam logic [10:0] RU_LAST = 11'd1071;
	localparam logic [4:0] EN_SIZE = 5'd26;
	localparam logic [4:0] EN_OFFSET_RES = 5'd13;
	localparam logic [4:0] RU_OFFSET_RES = 5'd16;
	localparam logic [17:0] EN_RECIP_CODE = 18'd161320;
	localparam logic [11:0] EN_RECIP_ACC = 12'd2521;

	localparam logic [2:0] REG_ALPHABET = 3'd0;
	localparam logic [2:0] REG_BLOCK_SIZE = 3'd1;
	localparam logic [2:0] REG_KEY_A = 3'd2;
	localparam logic [2:0] REG_KEY_B = 3'd3;
	localparam logic [2:0] REG_KEY_C = 3'd4;
	localparam logic [2:0] REG_KEY_D = 3'd5;

	typedef logic [MAX_SIZE-1:0][19:0] key_rows_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_MOD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic store;
		logic mac;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic load_out;
		logic blk_clr;
	} cmd_t;

	typedef struct packed {
		logic blk_full;
		logic col_last;
		logic row_last;
	} status_t;

endpackage

/* src/hbc_dp.sv */
// Datapath: letter reduction, block store, shared multiply-accumulate and output register.
module hbc_dp (
	input logic clk,
	input logic arst_n,
	input logic alphabet,
	input logic [2:0] block_size,
	input hbc_pkg::key_rows_t key_rows,
	input logic cfg_clr,
	input logic [15:0] char_code,
	input hbc_pkg::cmd_t cmd,
	output hbc_pkg::status_t status,
	output logic [10:0] out_char,
	output logic end_of_block,
	output logic bad_letter
);
	import hbc_pkg::*;

	logic [2:0] eff_n;
	logic [2:0] fill_q;
	logic [2:0] fill_idx;
	logic err_q;
	logic [4:0] store_q [MAX_SIZE];
	logic [33:0] code_prod;
	logic [11:0] code_quot;
	logic [16:0] code_q26;
	logic [15:0] code_diff;
	logic [4:0] code_res;
	logic [4:0] letter;
	logic bad;
	logic [19:0] key_row;
	logic [4:0] key_ent;
	logic [9:0] mac_prod;
	logic [11:0] acc_q;
	logic [23:0] acc_prod;
	logic [7:0] acc_quot;
	logic [11:0] acc_q26;
	logic [11:0] acc_diff;
	logic [4:0] residue;
	logic [10:0] out_char_q;
	logic eob_q;
	logic bad_q;

	always_comb begin
		if (block_size == 3'd0) begin
			eff_n = 3'd1;
		end else if (block_size > 3'(MAX_SIZE)) begin
			eff_n = 3'(MAX_SIZE);
		end else begin
			eff_n = block_size;
		end
	end

	assign fill_idx = (fill_q >= eff_n) ? 3'd0 : fill_q;

	// English letters are reduced with a reciprocal multiply, exact for 16-bit codes.
	assign code_prod = 34'(char_code) * 34'(EN_RECIP_CODE);
	assign code_quot = code_prod[33:22];
	assign code_q26 = {1'b0, code_quot, 4'b0} + {2'b0, code_quot, 3'b0}
		+ {4'b0, code_quot, 1'b0};
	assign code_diff = char_code - code_q26[15:0];
	assign code_res = code_diff[4:0];

	always_comb begin
		if (alphabet) begin
			letter = char_code[4:0] + RU_OFFSET_RES;
			bad = (11'(char_code) < RU_OFFSET) || (char_code > 16'(RU_LAST))
				|| (char_code[15:11] != 5'd0);
		end else begin
			letter = (code_res >= EN_OFFSET_RES) ? code_res - EN_OFFSET_RES
				: code_res + EN_OFFSET_RES;
			bad = (char_code < 16'(EN_OFFSET)) || (char_code > 16'(EN_LAST));
		end
	end

	assign status.blk_full = (fill_idx + 3'd1) >= eff_n;
	assign status.col_last = (3'(cmd.col) + 3'd1) == eff_n;
	assign status.row_last = (3'(cmd.row) + 3'd1) == eff_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
			err_q <= 1'b0;
		end else if (cfg_clr || cmd.blk_clr) begin
			fill_q <= 3'd0;
			err_q <= 1'b0;
		end else if (cmd.store) begin
			fill_q <= fill_idx + 3'd1;
			err_q <= err_q | bad;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[fill_idx[IDX_W-1:0]] <= letter;
		end
	end

	assign key_row = key_rows[cmd.row];
	assign key_ent = key_row[5 * cmd.col +: 5];
	assign mac_prod = key_ent * store_q[cmd.col];

	always_ff @(posedge clk) begin
		if (cmd.mac) begin
			acc_q <= (cmd.col == '0) ? 12'(mac_prod) : acc_q + 12'(mac_prod);
		end
	end

	assign acc_prod = 24'(acc_q) * 24'(EN_RECIP_ACC);
	assign acc_quot = acc_prod[23:16];
	assign acc_q26 = {acc_quot, 4'b0} + {1'b0, acc_quot, 3'b0} + {3'b0, acc_quot, 1'b0};
	assign acc_diff = acc_q - acc_q26;
	assign residue = alphabet ? acc_q[4:0] : acc_diff[4:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_char_q <= (alphabet ? RU_OFFSET : EN_OFFSET) + 11'(residue);
			eob_q <= status.row_last;
			bad_q <= err_q;
		end
	end

	assign out_char = out_char_q;
	assign end_of_block = eob_q;
	assign bad_letter = bad_q;

endmodule

/* src/hbc_ctrl.sv */
// Controller: sequences letter intake, the multiply-accumulate passes and result hand-off.
module hbc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input hbc_pkg::status_t status,
	output hbc_pkg::cmd_t cmd
);
	import hbc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.blk_full) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (status.col_last) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = status.row_last ? ST_IDLE : ST_MAC;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		cmd = '0;
		cmd.row = row_q;
		cmd.col = col_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.store = in_valid;
			end
			ST_MAC: begin
				cmd.mac = 1'b1;
			end
			ST_MOD: begin
				cmd.load_out = 1'b1;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				cmd.blk_clr = out_ready && status.row_last;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q <= '0;
			col_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				row_q <= '0;
				col_q <= '0;
			end else if (state_q == ST_MAC) begin
				col_q <= status.col_last ? '0 : col_q + 1'b1;
			end else if (state_q == ST_OUT && out_ready) begin
				row_q <= row_q + 1'b1;
				col_q <= '0;
			end
		end
	end

endmodule

/* src/hill_block_cipher.sv */
// Hill block cipher top level: configuration registers, controller and datapath.
//
// Input items arrive on the s_axis channel, one 16-bit character code per item.
// Output items leave on the m_axis channel, one cipher character per item, with
// tlast on the last character of a block and tuser set when any letter of
// that block lay outside the alphabet.
// The user must write configuration over the APB port only while the block is idle; the block does not enforce this.
// Writing the alphabet or block size discards a partial block.
// A letter that does not complete a block is stored and the block stays ready for
// the next one. After the letter that completes a block of n letters, each of the
// n results is accumulated over its key row on the one shared multiplier, then
// reduced modulo the alphabet size and registered for output, one row after another.
// Input is not accepted while a block's results are being computed or wait.
// When the receiver stalls, the pending result holds until it is taken.
// Reset returns the alphabet to English, the block size to two, the key to
// the identity matrix and empties the partial block.
module hill_block_cipher (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [15:0] s_axis_tdata, // [15:0] char_code
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // [10:0] out_char, [15:11] zero
	output logic m_axis_tlast,
	output logic [0:0] m_axis_tuser, // [0] bad_letter
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import hbc_pkg::*;

	logic alphabet_q;
	logic [2:0] block_size_q;
	key_rows_t key_q;
	logic cfg_wr;
	logic cfg_clr;
	logic [2:0] reg_idx;
	cmd_t cmd;
	status_t status;
	logic [10:0] out_char;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr = psel && penable && pwrite && pready;
	assign cfg_clr = cfg_wr && (reg_idx == REG_ALPHABET || reg_idx == REG_BLOCK_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alphabet_q <= 1'b0;
			block_size_q <= 3'd2;
			key_q[0] <= 20'd1;
			key_q[1] <= 20'd32;
			key_q[2] <= 20'd1024;
			key_q[3] <= 20'd32768;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ALPHABET: alphabet_q <= pwdata[0];
				REG_BLOCK_SIZE: block_size_q <= pwdata[2:0];
				REG_KEY_A: key_q[0] <= pwdata[19:0];
				REG_KEY_B: key_q[1] <= pwdata[19:0];
				REG_KEY_C: key_q[2] <= pwdata[19:0];
				REG_KEY_D: key_q[3] <= pwdata[19:0];
				default: alphabet_q <= alphabet_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ALPHABET: prdata = {31'd0, alphabet_q};
			REG_BLOCK_SIZE: prdata = {29'd0, block_size_q};
			REG_KEY_A: prdata = {12'd0, key_q[0]};
			REG_KEY_B: prdata = {12'd0, key_q[1]};
			REG_KEY_C: prdata = {12'd0, key_q[2]};
			REG_KEY_D: prdata = {12'd0, key_q[3]};
			default: prdata = 32'd0;
		endcase
	end

	hbc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.status(status),
		.cmd(cmd)
	);

	hbc_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.alphabet(alphabet_q),
		.block_size(block_size_q),
		.key_rows(key_q),
		.cfg_clr(cfg_clr),
		.char_code(s_axis_tdata),
		.cmd(cmd),
		.status(status),
		.out_char(out_char),
		.end_of_block(m_axis_tlast),
		.bad_letter(m_axis_tuser[0])
	);

	assign m_axis_tdata = {5'd0, out_char};

`include "hill_block_cipher_assert.svh"

	`HBC_ASSERT_NOW(a_one_side, m_axis_tvalid, !s_axis_tready, "input taken while a result waits")
	`HBC_ASSERT_NEXT(a_back_idle, m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready,
		"block not idle after its last item")
	`HBC_ASSERT_NOW(a_en_range, m_axis_tvalid && !alphabet_q,
		out_char >= EN_OFFSET && out_char <= EN_LAST, "English result out of range")
	`HBC_ASSERT_NOW(a_ru_range, m_axis_tvalid && alphabet_q,
		out_char >= RU_OFFSET && out_char <= RU_LAST, "Russian result out of range")

endmodule

/* sim/hill_block_cipher_check.sv */
`timescale 1ns / 1ps
// Checker for the Hill block cipher: mirrors its registers, predicts results and compares.
module hill_block_cipher_check (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [15:0] m_axis_tdata,
	input logic m_axis_tlast,
	input logic [0:0] m_axis_tuser,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	input logic pready,
	output int fail_count,
	output int pending
);
	import hbc_pkg::*;

	localparam int unsigned EN_LETTERS = 26;
	localparam int unsigned RU_LETTERS = 32;

	typedef struct packed {
		logic [10:0] code;
		logic last;
		logic bad;
	} cipher_char_t;

	cipher_char_t expected_chars[$];
	logic russian;
	logic [2:0] block_len;
	logic [19:0] key_row [MAX_SIZE];
	logic [4:0] letters [MAX_SIZE];
	logic [2:0] fill;
	logic bad_seen;

	task automatic flag_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		fail_count++;
	endtask

	task automatic encipher_letter(input logic [15:0] code);
		int unsigned modulus;
		int unsigned base;
		int unsigned n;
		int unsigned letter;
		int unsigned acc;
		cipher_char_t ch;
		modulus = russian ? RU_LETTERS : EN_LETTERS;
		base = russian ? RU_OFFSET : EN_OFFSET;
		n = (block_len == 0) ? 1 : ((block_len > MAX_SIZE) ? MAX_SIZE : block_len);
		letter = (code + modulus * 64 - base) % modulus;
		if (code < base || code > base + modulus - 1)
			bad_seen = 1'b1;
		if (fill >= n)
			fill = 3'd0;
		letters[fill[1:0]] = 5'(letter);
		fill = fill + 3'd1;
		if (fill >= n) begin
			for (int i = 0; i < n; i++) begin
				acc = 0;
				for (int j = 0; j < n; j++)
					acc += key_row[i][5*j +: 5] * letters[j];
				ch.code = 11'(base + acc % modulus);
				ch.last = (i == n - 1);
				ch.bad = bad_seen;
				expected_chars = {expected_chars, ch};
			end
			fill = 3'd0;
			bad_seen = 1'b0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		cipher_char_t want;
		if (!arst_n) begin
			russian = 1'b0;
			block_len = 3'd2;
			key_row[0] = 20'd1;
			key_row[1] = 20'd32;
			key_row[2] = 20'd1024;
			key_row[3] = 20'd32768;
			fill = 3'd0;
			bad_seen = 1'b0;
			fail_count = 0;
			expected_chars.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_ALPHABET: begin
						russian = pwdata[0];
						fill = 3'd0;
						bad_seen = 1'b0;
					end
					REG_BLOCK_SIZE: begin
						block_len = pwdata[2:0];
						fill = 3'd0;
						bad_seen = 1'b0;
					end
					REG_KEY_A: key_row[0] = pwdata[19:0];
					REG_KEY_B: key_row[1] = pwdata[19:0];
					REG_KEY_C: key_row[2] = pwdata[19:0];
					REG_KEY_D: key_row[3] = pwdata[19:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				encipher_letter(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_chars.size() == 0) begin
					flag_error($sformatf("unexpected cipher item, tdata %0d",
						m_axis_tdata));
				end else begin
					want = expected_chars.pop_front();
					if (m_axis_tdata != {5'd0, want.code})
						flag_error($sformatf("out_char %0d, expected %0d",
							m_axis_tdata, want.code));
					if (m_axis_tlast != want.last)
						flag_error($sformatf("end_of_block %0d, expected %0d",
							m_axis_tlast, want.last));
					if (m_axis_tuser[0] != want.bad)
						flag_error($sformatf("bad_letter %0d, expected %0d",
							m_axis_tuser[0], want.bad));
				end
			end
			pending <= expected_chars.size();
		end
	end

endmodule

/* sim/hill_block_cipher_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the Hill block cipher: clock, reset, stimulus, register writes and verdict.
module hill_block_cipher_tb;
	import hbc_pkg::*;

	localparam int HOLD_LEN = 250;
	localparam int SETTLE = 40;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 38;
	localparam int unsigned RU_LETTERS = 32;
	localparam logic [2:0] REG_SPARE = 3'd6;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic m_axis_tlast;
	logic [0:0] m_axis_tuser;
	logic psel;
	logic penable;
	logic pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int pending;
	int quiet_cycles;
	bit calm;
	bit hold_req;
	logic ru_mode;

	hill_block_cipher uut (.*);

	hill_block_cipher_check check (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("** hill_block_cipher: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		bit hold_seen;
		m_axis_tready = 1'b0;
		hold_seen = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				m_axis_tready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= 29);
			end
		end
	end

	task automatic send_char(input logic [15:0] code);
		while (!calm && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_key(input logic [31:0] row_value);
		for (int k = 0; k < MAX_SIZE; k++)
			apb_write(3'(REG_KEY_A + k), row_value);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_code(input logic ru);
		logic [15:0] base;
		int unsigned span;
		int unsigned r;
		base = ru ? 16'(RU_OFFSET) : 16'(EN_OFFSET);
		span = ru ? RU_LETTERS : int'(EN_SIZE);
		r = $urandom_range(99);
		if (r < 80)
			return base + 16'($urandom_range(span - 1));
		if (r < 86)
			return $urandom_range(1) ? base - 16'd1 : base + 16'(span);
		if (r < 90)
			return (ru ? 16'(EN_OFFSET) : 16'(RU_OFFSET)) + 16'($urandom_range(25));
		return 16'($urandom);
	endfunction

	initial begin
		logic [31:0] size_val;
		logic [31:0] key_val;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 16'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 5'd0;
		pwdata = 32'd0;
		calm = 1'b0;
		hold_req = 1'b0;
		ru_mode = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: English, pairs, identity key; letters at and beyond both ends.
		send_char(16'd65);
		send_char(16'd90);
		send_char(16'd64);
		send_char(16'd91);
		send_char(16'd0);
		send_char(16'hFFFF);
		drain_results();
		apb_write(REG_SPARE, 32'hFFFF_FFFF);
		send_char(16'd66);
		send_char(16'd67);
		drain_results();

		// Russian, largest block, every key entry at its maximum.
		ru_mode = 1'b1;
		apb_write(REG_ALPHABET, 32'd1);
		apb_write(REG_BLOCK_SIZE, 32'd4);
		load_key(32'h000F_FFFF);
		send_char(16'd1040);
		send_char(16'd1071);
		send_char(16'd1039);
		send_char(16'd1072);
		send_char(16'd1041);
		drain_results();

		// A block size of zero acts as one and drops the partial block.
		apb_write(REG_BLOCK_SIZE, 32'd0);
		send_char(16'd1050);
		send_char(16'd1055);
		drain_results();

		// A block size above the maximum acts as the maximum.
		ru_mode = 1'b0;
		apb_write(REG_ALPHABET, 32'd0);
		apb_write(REG_BLOCK_SIZE, 32'd7);
		apb_write(REG_KEY_A, 32'd0);
		send_char(16'd65);
		send_char(16'd90);
		send_char(16'd77);
		send_char(16'd1040);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			calm = 1'b0;
			ru_mode = 1'($urandom_range(1));
			if (ph == 0)
				size_val = 32'd1;
			else if (ph == 1)
				size_val = 32'd4;
			else if ($urandom_range(99) < 75)
				size_val = $urandom_range(1, 4);
			else begin
				size_val = $urandom_range(4, 7);
				if (size_val == 32'd4)
					size_val = 32'd0;
			end
			apb_write(REG_ALPHABET, {31'd0, ru_mode});
			apb_write(REG_BLOCK_SIZE, size_val);
			for (int k = 0; k < MAX_SIZE; k++) begin
				if (ph == 3)
					key_val = 32'd0;
				else if (ph == 4)
					key_val = 32'h000F_FFFF;
				else
					key_val = $urandom_range(0, 32'h000F_FFFF);
				apb_write(3'(REG_KEY_A + k), key_val);
			end
			calm = (ph == 5);
			if (ph == 2)
				hold_req <= ~hold_req;
			repeat (PHASE_ITEMS) send_char(pick_code(ru_mode));
		end
		drain_results();

		if (fail_count == 0)
			$display("** hill_block_cipher: PASSED **");
		else
			$display("** hill_block_cipher: FAILED **");
		$finish;
	end

endmodule
